[hw/rtl/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants, codes and controller/datapath interface types of the
// signed distance field sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  // Default geometry, overridable on the top level
  localparam int unsigned MaxImageDim  = 256;
  localparam int unsigned SearchRadius = 512;

  // Fixed field widths
  localparam int unsigned DimW     = 9;
  localparam int unsigned PosW     = 8;
  localparam int unsigned PixW     = 8;
  localparam int unsigned DistW    = 19;
  localparam int unsigned MagW     = DistW + 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned FracBits = 8;

  localparam int unsigned CoverThreshold = 127;
  localparam int unsigned DistPosMax     = (2 ** (DistW - 1)) - 1;

  // Register reset values
  localparam int unsigned InWidthRst   = 256;
  localparam int unsigned InHeightRst  = 256;
  localparam int unsigned OutWidthRst  = 32;
  localparam int unsigned OutHeightRst = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgInWidth   = 2'd0,
    CfgInHeight  = 2'd1,
    CfgOutWidth  = 2'd2,
    CfgOutHeight = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OpLoad  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct packed {
    logic in_accept;
    logic clr_step;
    logic div_start;
    logic win;
    logic self_cap;
    logic scan_step;
    logic sqrt_start;
    logic post;
  } sdf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic div_busy;
    logic scan_last;
    logic pipe_empty;
    logic sqrt_busy;
    logic out_busy;
  } sdf_sts_t;

endpackage

`default_nettype wire

[hw/rtl/sdf_div.sv]
// ----------------------------------------------------------------------------
// sdf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_div #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 9,
  parameter int unsigned QW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [QW-1:0] quot_o
);
  import sdf_pkg::*;

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            take;

  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign take    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // numerator register shifts quotient bits in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], take};
      rem_q <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = num_q[QW-1:0];

endmodule

`default_nettype wire

[hw/rtl/sdf_sqrt.sv]
// ----------------------------------------------------------------------------
// sdf_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_sqrt #(
  parameter int unsigned IW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [IW-1:0]   rad_i,
  output logic            busy_o,
  output logic [IW/2-1:0] root_o
);
  import sdf_pkg::*;

  localparam int unsigned RW   = IW / 2;
  localparam int unsigned CntW = $clog2(RW + 1);

  logic [IW-1:0]   rad_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   rem_sub;
  logic            take;

  assign rem_sh  = {rem_q, rad_q[IW-1:IW-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign take    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[IW-3:0], 2'b00};
      rem_q  <= take ? rem_sub[RW:0] : rem_sh[RW:0];
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[hw/rtl/sdf_datapath.sv]
// ----------------------------------------------------------------------------
// sdf_datapath
// Config registers, bitmap memory, coordinate mapping, window scan pipeline,
// square root and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_datapath #(
  parameter int unsigned MAX_IMAGE_DIM = sdf_pkg::MaxImageDim,
  parameter int unsigned SEARCH_RADIUS = sdf_pkg::SearchRadius
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [sdf_pkg::DimW-1:0]           cfg_data_i,
  input  logic                               operation_i,
  input  logic [sdf_pkg::PosW-1:0]           pos_x_i,
  input  logic [sdf_pkg::PosW-1:0]           pos_y_i,
  input  logic [sdf_pkg::PixW-1:0]           pixel_i,
  input  logic                               out_ready_i,
  input  sdf_pkg::sdf_cmd_t                  cmd_i,
  output sdf_pkg::sdf_sts_t                  sts_o,
  output logic                               out_valid_o,
  output logic signed [sdf_pkg::DistW-1:0]   distance_o,
  output logic signed [sdf_pkg::DistW-1:0]   max_inside_o,
  output logic signed [sdf_pkg::DistW-1:0]   min_outside_o,
  output logic                               bad_coord_o
);
  import sdf_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_IMAGE_DIM);
  localparam int unsigned EW    = $clog2(MAX_IMAGE_DIM + 1);
  localparam int unsigned Depth = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAX_IMAGE_DIM + SEARCH_RADIUS + 1);
  localparam int unsigned NW    = PosW + EW;
  localparam int unsigned D2W   = 2 * CW + 1;
  localparam int unsigned SQW   = ((D2W + 2 * FracBits + 1) / 2) * 2;
  localparam int unsigned RW    = SQW / 2;
  localparam int unsigned Cap   = SEARCH_RADIUS * (2 ** FracBits);

  localparam logic [AW-1:0]   RowStride = AW'(MAX_IMAGE_DIM);
  localparam logic [XW-1:0]   RadE      = XW'(SEARCH_RADIUS);
  localparam logic [MagW-1:0] CapE      = MagW'(Cap);
  localparam logic [MagW-1:0] PosMaxE   = MagW'(DistPosMax);
  localparam logic [DistW-1:0] LargestRst  = DistW'(-(int'(Cap)));
  localparam logic [DistW-1:0] SmallestRst = (Cap > DistPosMax) ? DistW'(DistPosMax)
                                                                : DistW'(Cap);

  // ---------------- configuration ----------------
  logic [DimW-1:0] in_w_q, in_h_q, out_w_q, out_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_w_q  <= DimW'(InWidthRst);
      in_h_q  <= DimW'(InHeightRst);
      out_w_q <= DimW'(OutWidthRst);
      out_h_q <= DimW'(OutHeightRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgInWidth:   in_w_q  <= cfg_data_i;
        CfgInHeight:  in_h_q  <= cfg_data_i;
        CfgOutWidth:  out_w_q <= cfg_data_i;
        CfgOutHeight: out_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [EW-1:0]   iw, ih;
  logic [DimW-1:0] ow, oh;

  always_comb begin
    if (in_w_q == '0) begin
      iw = EW'(1);
    end else if (int'(in_w_q) > MAX_IMAGE_DIM) begin
      iw = EW'(MAX_IMAGE_DIM);
    end else begin
      iw = EW'(in_w_q);
    end
    if (in_h_q == '0) begin
      ih = EW'(1);
    end else if (int'(in_h_q) > MAX_IMAGE_DIM) begin
      ih = EW'(MAX_IMAGE_DIM);
    end else begin
      ih = EW'(in_h_q);
    end
    ow = (out_w_q == '0) ? DimW'(1) : out_w_q;
    oh = (out_h_q == '0) ? DimW'(1) : out_h_q;
  end

  // ---------------- input capture and loads ----------------
  logic [PosW-1:0] px_q, py_q;
  logic            load_we;
  logic [AW-1:0]   load_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_accept) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  assign load_we = cmd_i.in_accept && (operation_i == OpLoad) &&
                   (32'(pos_x_i) < 32'(iw)) && (32'(pos_y_i) < 32'(ih));
  assign load_addr = AW'(pos_y_i) * RowStride + AW'(pos_x_i);

  assign sts_o.bad = (DimW'(px_q) >= ow) || (DimW'(py_q) >= oh);

  // ---------------- clearing sweep ----------------
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign sts_o.clr_last = clr_cnt_q == AW'(Depth - 1);

  // ---------------- coordinate mapping ----------------
  logic [NW-1:0] num_x, num_y;
  logic [CW-1:0] cx, cy;
  logic          busy_x, busy_y;

  assign num_x = NW'(px_q) * NW'(iw);
  assign num_y = NW'(py_q) * NW'(ih);

  sdf_div #(.NW(NW), .DW(DimW), .QW(CW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_x),
    .den_i   (ow),
    .busy_o  (busy_x),
    .quot_o  (cx)
  );

  sdf_div #(.NW(NW), .DW(DimW), .QW(CW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_y),
    .den_i   (oh),
    .busy_o  (busy_y),
    .quot_o  (cy)
  );

  assign sts_o.div_busy = busy_x || busy_y;

  // ---------------- search window ----------------
  logic [XW-1:0] cx_e, cy_e, xs, ys;
  logic [CW-1:0] x0, xl, y0, yl;
  logic [CW-1:0] x0_q, xl_q, yl_q, ix_q, iy_q;

  always_comb begin
    cx_e = XW'(cx);
    cy_e = XW'(cy);
    xs   = cx_e + RadE;
    ys   = cy_e + RadE;
    x0   = (cx_e >= RadE) ? CW'(cx_e - RadE) : '0;
    y0   = (cy_e >= RadE) ? CW'(cy_e - RadE) : '0;
    xl   = (xs > XW'(iw)) ? CW'(XW'(iw) - XW'(1)) : CW'(xs - XW'(1));
    yl   = (ys > XW'(ih)) ? CW'(XW'(ih) - XW'(1)) : CW'(ys - XW'(1));
  end

  assign sts_o.scan_last = (ix_q == xl_q) && (iy_q == yl_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.win) begin
      x0_q <= x0;
      xl_q <= xl;
      yl_q <= yl;
      ix_q <= x0;
      iy_q <= y0;
    end else if (cmd_i.scan_step) begin
      if (ix_q == xl_q) begin
        ix_q <= x0_q;
        iy_q <= iy_q + CW'(1);
      end else begin
        ix_q <= ix_q + CW'(1);
      end
    end
  end

  // ---------------- bitmap memory ----------------
  logic          mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          rd_q;

  assign mem_we    = cmd_i.clr_step || load_we;
  assign mem_waddr = cmd_i.clr_step ? clr_cnt_q : load_addr;
  assign mem_wdata = !cmd_i.clr_step && (pixel_i > PixW'(CoverThreshold));
  assign mem_raddr = cmd_i.scan_step ? AW'(iy_q) * RowStride + AW'(ix_q)
                                     : AW'(cy) * RowStride + AW'(cx);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  // ---------------- scan pipeline ----------------
  logic                self_q;
  logic                va_q, vb_q;
  logic [CW-1:0]       adx_q, ady_q;
  logic [2*CW-1:0]     sqx_q, sqy_q;
  logic [D2W-1:0]      d2;
  logic [D2W-1:0]      best_q;
  logic                found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= cmd_i.scan_step;
      vb_q <= va_q && (rd_q != self_q);
    end
  end

  assign d2 = D2W'(sqx_q) + D2W'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.self_cap) begin
      self_q <= rd_q;
    end
    adx_q <= (ix_q >= cx) ? ix_q - cx : cx - ix_q;
    ady_q <= (iy_q >= cy) ? iy_q - cy : cy - iy_q;
    sqx_q <= (2 * CW)'(adx_q) * (2 * CW)'(adx_q);
    sqy_q <= (2 * CW)'(ady_q) * (2 * CW)'(ady_q);
    if (cmd_i.win) begin
      best_q  <= '1;
      found_q <= 1'b0;
    end else if (vb_q && (d2 < best_q)) begin
      best_q  <= d2;
      found_q <= 1'b1;
    end
  end

  assign sts_o.pipe_empty = !va_q && !vb_q;

  // ---------------- square root ----------------
  logic [SQW-1:0] rad;
  logic [RW-1:0]  root;

  assign rad = SQW'(best_q) << (2 * FracBits);

  sdf_sqrt #(.IW(SQW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (rad),
    .busy_o  (sts_o.sqrt_busy),
    .root_o  (root)
  );

  // ---------------- result and running extremes ----------------
  logic [MagW-1:0]  root_e, mag, pos_sat, neg;
  logic [DistW-1:0] largest_q, smallest_q;
  logic [DistW-1:0] largest_d, smallest_d, dist_d;
  logic             out_valid_q;

  always_comb begin
    root_e     = MagW'(root);
    mag        = (found_q && (root_e < CapE)) ? root_e : CapE;
    pos_sat    = (mag > PosMaxE) ? PosMaxE : mag;
    neg        = -mag;
    largest_d  = largest_q;
    smallest_d = smallest_q;
    dist_d     = '0;
    if (!sts_o.bad) begin
      if (self_q) begin
        dist_d = pos_sat[DistW-1:0];
        if ($signed(pos_sat) > $signed({largest_q[DistW-1], largest_q})) begin
          largest_d = pos_sat[DistW-1:0];
        end
      end else begin
        dist_d = neg[DistW-1:0];
        if ($signed(neg) < $signed({smallest_q[DistW-1], smallest_q})) begin
          smallest_d = neg[DistW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q   <= LargestRst;
      smallest_q  <= SmallestRst;
      out_valid_q <= 1'b0;
    end else if (cmd_i.post) begin
      largest_q   <= largest_d;
      smallest_q  <= smallest_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      distance_o    <= dist_d;
      max_inside_o  <= largest_d;
      min_outside_o <= smallest_d;
      bad_coord_o   <= sts_o.bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

[hw/rtl/sdf_ctrl.sv]
// ----------------------------------------------------------------------------
// sdf_ctrl
// Sequencer: memory clear after reset, load/query intake, mapping, window
// scan, square root and result posting.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  output logic              in_ready_o,
  input  sdf_pkg::sdf_sts_t sts_i,
  output sdf_pkg::sdf_cmd_t cmd_o
);
  import sdf_pkg::*;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StCheck,
    StDiv,
    StWin,
    StSelf,
    StScan,
    StDrain,
    StSqrt,
    StPost
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o      = 1'b1;
        cmd_o.in_accept = in_valid_i;
        if (in_valid_i && (operation_i == OpQuery)) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.bad) begin
          state_d = StPost;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (!sts_i.div_busy) begin
          state_d = StWin;
        end
      end
      StWin: begin
        cmd_o.win = 1'b1;
        state_d   = StSelf;
      end
      StSelf: begin
        cmd_o.self_cap = 1'b1;
        state_d        = StScan;
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (sts_i.pipe_empty) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = StSqrt;
        end
      end
      StSqrt: begin
        if (!sts_i.sqrt_busy) begin
          state_d = StPost;
        end
      end
      StPost: begin
        // hold until the result register is free
        if (!sts_i.out_busy) begin
          cmd_o.post = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/signed_distance_field_sampler_unit.sv]
// ----------------------------------------------------------------------------
// signed_distance_field_sampler_unit
// Brute-force signed distance field sampler over a one-bit glyph bitmap.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is swept to zero, one entry per cycle, over all
// MAX_IMAGE_DIM*MAX_IMAGE_DIM entries (65536 by default); configuration writes
// are taken during the sweep but no item is. A load is written to the bitmap
// as it is accepted. A query maps its grid point through two bit-serial
// dividers, then reads the clamped search window from the bitmap memory, one
// pixel per cycle over its single read port, and finishes with a bit-serial
// square root. An out-of-range query skips mapping, scan and square root and
// goes straight to posting its result. One item is in flight at a time; a
// finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_distance_field_sampler_unit #(
  parameter int unsigned MAX_IMAGE_DIM = sdf_pkg::MaxImageDim,
  parameter int unsigned SEARCH_RADIUS = sdf_pkg::SearchRadius
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sdf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sdf_pkg::DimW-1:0]         cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             operation_i,
  input  logic [sdf_pkg::PosW-1:0]         pos_x_i,
  input  logic [sdf_pkg::PosW-1:0]         pos_y_i,
  input  logic [sdf_pkg::PixW-1:0]         pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sdf_pkg::DistW-1:0] distance_o,
  output logic signed [sdf_pkg::DistW-1:0] max_inside_o,
  output logic signed [sdf_pkg::DistW-1:0] min_outside_o,
  output logic                             bad_coord_o
);
  import sdf_pkg::*;

  sdf_cmd_t cmd;
  sdf_sts_t sts;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  sdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdf_datapath #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .SEARCH_RADIUS (SEARCH_RADIUS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pixel_i       (pixel_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .distance_o    (distance_o),
    .max_inside_o  (max_inside_o),
    .min_outside_o (min_outside_o),
    .bad_coord_o   (bad_coord_o)
  );

endmodule

`default_nettype wire
